### hdl/bpes_pkg.sv
`default_nettype none

package bpes_pkg;

    localparam int STATE_W       = 32;   // position / velocity word
    localparam int COEF_W        = 16;   // drag and time step registers
    localparam int GRAV_W        = 24;
    localparam int BOX_W         = 12;
    localparam int PIX_W         = 16;
    localparam int CFG_DATA_W    = 24;
    localparam int CFG_ADDR_W    = 3;
    localparam int REG_FRAC      = 16;   // fraction bits of the Q.16 registers
    localparam int FRAC_BITS_DEF = 16;

    // shared multiplier: signed accumulator operand times unsigned coefficient
    localparam int ACC_W  = 35;
    localparam int PROD_W = ACC_W + COEF_W;
    localparam int SH_W   = PROD_W - REG_FRAC;
    localparam int SUM_W  = SH_W + 1;

    localparam logic [COEF_W-1:0] DRAG_RST = 16'd6554;
    localparam logic [GRAV_W-1:0] GRAV_RST = 24'd642253;
    localparam logic [COEF_W-1:0] DT_RST   = 16'd2185;
    localparam logic [BOX_W-1:0]  BOX_RST  = 12'd105;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DRAG   = 3'd0,
        CFG_GRAV   = 3'd1,
        CFG_DT     = 3'd2,
        CFG_WIDTH  = 3'd3,
        CFG_HEIGHT = 3'd4
    } cfg_idx_t;

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-STATE_W:0] top;
        top = v[SUM_W-1:STATE_W-1];
        if ((&top) || !(|top)) begin
            return v[STATE_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(STATE_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

### hdl/bpes_mul.sv
`default_nettype none

module bpes_mul
    import bpes_pkg::*;
(
    input  wire                       aclk,
    input  wire logic signed [ACC_W-1:0]  op_a,
    input  wire logic        [COEF_W-1:0] op_b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // |op_a| <= 2^34 and op_b < 2^16, so the product fits PROD_W signed bits
    assign prod_next = op_a * $signed({1'b0, op_b});

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### hdl/bouncing_particle_euler_step_top.sv
`default_nettype none

// channel   direction  handshake           payload
// s_*       in         s_valid / s_ready   s_opcode, s_load_pos_x/y, s_load_vel_x/y
// m_*       out        m_valid / m_ready   m_pixel_x/y, m_bounced_x/y
// cfg_*     in         cfg_wr_en           cfg_addr, cfg_wr_data
//
// A load word goes from accept to the output step; a tick does two wall tests
// and two axis updates (drag, velocity, position), all on one shared 35x16
// multiplier with a registered product, plus accept and output steps.
// s_ready is high only while the sequencer is idle; a word can be accepted while
// the previous result still waits in the output register.
// aresetn is synchronous: state, particle and registers return to defaults.

module bouncing_particle_euler_step_top
    import bpes_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,

    input  wire                          cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wr_data,

    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire logic                    s_opcode,
    input  wire logic signed [STATE_W-1:0] s_load_pos_x,
    input  wire logic signed [STATE_W-1:0] s_load_pos_y,
    input  wire logic signed [STATE_W-1:0] s_load_vel_x,
    input  wire logic signed [STATE_W-1:0] s_load_vel_y,

    output logic                         m_valid,
    input  wire                          m_ready,
    output logic signed [PIX_W-1:0]      m_pixel_x,
    output logic signed [PIX_W-1:0]      m_pixel_y,
    output logic                         m_bounced_x,
    output logic                         m_bounced_y
);

    localparam int CMP_W = (FRAC_BITS + 14 > 36) ? FRAC_BITS + 14 : 36;
    localparam int GT_W  = FRAC_BITS + 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALL_MUL,
        ST_WALL_CHK,
        ST_DRAG_MUL,
        ST_DRAG_SUB,
        ST_ACC_MUL,
        ST_VEL_UPD,
        ST_POS_MUL,
        ST_POS_UPD,
        ST_OUT
    } st_t;

    st_t state_reg, state_next;
    logic axis_reg, axis_next;   // 0 = x, 1 = y

    logic [COEF_W-1:0] drag_reg, drag_next;
    logic [GRAV_W-1:0] grav_reg, grav_next;
    logic [COEF_W-1:0] dt_reg, dt_next;
    logic [BOX_W-1:0]  width_reg, width_next;
    logic [BOX_W-1:0]  height_reg, height_next;

    logic signed [STATE_W-1:0] pos_x_reg, pos_x_next;
    logic signed [STATE_W-1:0] pos_y_reg, pos_y_next;
    logic signed [STATE_W-1:0] vel_x_reg, vel_x_next;
    logic signed [STATE_W-1:0] vel_y_reg, vel_y_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic bx_reg, bx_next;
    logic by_reg, by_next;

    logic m_valid_reg, m_valid_next;
    logic signed [PIX_W-1:0] m_pixel_x_reg, m_pixel_x_next;
    logic signed [PIX_W-1:0] m_pixel_y_reg, m_pixel_y_next;
    logic m_bounced_x_reg, m_bounced_x_next;
    logic m_bounced_y_reg, m_bounced_y_next;

    logic signed [ACC_W-1:0]  mul_a;
    logic        [COEF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [SH_W-1:0]   prod_sh;

    logic signed [STATE_W-1:0] pos_cur, vel_cur, vel_neg;
    logic        [BOX_W-1:0]   size_cur;
    logic signed [BOX_W:0]     size_m1;
    logic signed [CMP_W-1:0]   pred, cmp_lo, cmp_hi;
    logic                      hit;
    logic [GRAV_W+FRAC_BITS-1:0] g_wide;
    logic signed [ACC_W-1:0]   gterm;
    logic signed [SUM_W-1:0]   vel_sum, pos_sum;

    function automatic logic signed [PIX_W-1:0] to_pixel(
        input logic signed [STATE_W-1:0] pos,
        input logic signed [STATE_W-1:0] vel
    );
        logic signed [STATE_W:0] bias;
        logic signed [STATE_W:0] s;
        logic signed [STATE_W:0] p;
        // ceil unless moving toward minus
        bias = vel[STATE_W-1] ? '0 : (({{STATE_W{1'b0}}, 1'b1} << FRAC_BITS) - 1'b1);
        s = {pos[STATE_W-1], pos} + bias;
        p = s >>> FRAC_BITS;
        if (p > $signed({{(STATE_W-PIX_W+2){1'b0}}, {(PIX_W-1){1'b1}}})) begin
            return {1'b0, {(PIX_W-1){1'b1}}};
        end else if (p < $signed({{(STATE_W-PIX_W+2){1'b1}}, {(PIX_W-1){1'b0}}})) begin
            return {1'b1, {(PIX_W-1){1'b0}}};
        end else begin
            return p[PIX_W-1:0];
        end
    endfunction

    bpes_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // floor(prod / 2^16)
    assign prod_sh = prod[PROD_W-1:REG_FRAC];

    assign pos_cur  = axis_reg ? pos_y_reg : pos_x_reg;
    assign vel_cur  = axis_reg ? vel_y_reg : vel_x_reg;
    assign size_cur = axis_reg ? height_reg : width_reg;

    assign mul_a = (state_reg == ST_ACC_MUL) ? acc_reg
                 : {{(ACC_W-STATE_W){vel_cur[STATE_W-1]}}, vel_cur};
    assign mul_b = (state_reg == ST_DRAG_MUL) ? drag_reg : dt_reg;

    assign vel_neg = (vel_cur == {1'b1, {(STATE_W-1){1'b0}}})
                   ? {1'b0, {(STATE_W-1){1'b1}}} : -vel_cur;

    assign size_m1 = $signed({1'b0, size_cur} - {{BOX_W{1'b0}}, 1'b1});
    assign cmp_lo  = {{(CMP_W-1){1'b0}}, 1'b1} << FRAC_BITS;
    assign cmp_hi  = {{(CMP_W-BOX_W-1){size_m1[BOX_W]}}, size_m1} << FRAC_BITS;
    assign pred    = {{(CMP_W-STATE_W){pos_cur[STATE_W-1]}}, pos_cur}
                   + {{(CMP_W-SH_W){prod_sh[SH_W-1]}}, prod_sh};
    assign hit     = (pred <= cmp_lo) || (pred >= cmp_hi);

    // gravity brought from Q8.16 to FRAC_BITS fraction bits, floored
    assign g_wide = {grav_reg, {FRAC_BITS{1'b0}}};
    assign gterm  = {{(ACC_W-GT_W){1'b0}}, g_wide[GRAV_W+FRAC_BITS-1:REG_FRAC]};

    assign vel_sum = {{(SUM_W-STATE_W){vel_cur[STATE_W-1]}}, vel_cur}
                   + {prod_sh[SH_W-1], prod_sh};
    assign pos_sum = {{(SUM_W-STATE_W){pos_cur[STATE_W-1]}}, pos_cur}
                   + {prod_sh[SH_W-1], prod_sh};

    always_comb begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        drag_next   = drag_reg;
        grav_next   = grav_reg;
        dt_next     = dt_reg;
        width_next  = width_reg;
        height_next = height_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        vel_x_next  = vel_x_reg;
        vel_y_next  = vel_y_reg;
        acc_next    = acc_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_pixel_x_next   = m_pixel_x_reg;
        m_pixel_y_next   = m_pixel_y_reg;
        m_bounced_x_next = m_bounced_x_reg;
        m_bounced_y_next = m_bounced_y_reg;

        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_DRAG:   drag_next   = cfg_wr_data[COEF_W-1:0];
                CFG_GRAV:   grav_next   = cfg_wr_data[GRAV_W-1:0];
                CFG_DT:     dt_next     = cfg_wr_data[COEF_W-1:0];
                CFG_WIDTH:  width_next  = cfg_wr_data[BOX_W-1:0];
                CFG_HEIGHT: height_next = cfg_wr_data[BOX_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    bx_next   = 1'b0;
                    by_next   = 1'b0;
                    axis_next = 1'b0;
                    if (s_opcode) begin
                        pos_x_next = s_load_pos_x;
                        pos_y_next = s_load_pos_y;
                        vel_x_next = s_load_vel_x;
                        vel_y_next = s_load_vel_y;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_WALL_MUL;
                    end
                end
            end
            ST_WALL_MUL: state_next = ST_WALL_CHK;
            ST_WALL_CHK: begin
                if (hit) begin
                    if (axis_reg) begin
                        vel_y_next = vel_neg;
                        by_next    = 1'b1;
                    end else begin
                        vel_x_next = vel_neg;
                        bx_next    = 1'b1;
                    end
                end
                if (axis_reg) begin
                    axis_next  = 1'b0;
                    state_next = ST_DRAG_MUL;
                end else begin
                    axis_next  = 1'b1;
                    state_next = ST_WALL_MUL;
                end
            end
            ST_DRAG_MUL: state_next = ST_DRAG_SUB;
            ST_DRAG_SUB: begin
                acc_next   = (axis_reg ? gterm : '0) - prod_sh;
                state_next = ST_ACC_MUL;
            end
            ST_ACC_MUL: state_next = ST_VEL_UPD;
            ST_VEL_UPD: begin
                if (axis_reg) begin
                    vel_y_next = sat_state(vel_sum);
                end else begin
                    vel_x_next = sat_state(vel_sum);
                end
                state_next = ST_POS_MUL;
            end
            ST_POS_MUL: state_next = ST_POS_UPD;
            ST_POS_UPD: begin
                if (axis_reg) begin
                    pos_y_next = sat_state(pos_sum);
                    axis_next  = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    pos_x_next = sat_state(pos_sum);
                    axis_next  = 1'b1;
                    state_next = ST_DRAG_MUL;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_pixel_x_next   = to_pixel(pos_x_reg, vel_x_reg);
                    m_pixel_y_next   = to_pixel(pos_y_reg, vel_y_reg);
                    m_bounced_x_next = bx_reg;
                    m_bounced_y_next = by_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            axis_reg    <= 1'b0;
            drag_reg    <= DRAG_RST;
            grav_reg    <= GRAV_RST;
            dt_reg      <= DT_RST;
            width_reg   <= BOX_RST;
            height_reg  <= BOX_RST;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
            bx_reg      <= 1'b0;
            by_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            drag_reg    <= drag_next;
            grav_reg    <= grav_next;
            dt_reg      <= dt_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            vel_x_reg   <= vel_x_next;
            vel_y_reg   <= vel_y_next;
            bx_reg      <= bx_next;
            by_reg      <= by_next;
            m_valid_reg <= m_valid_next;
        end
        acc_reg         <= acc_next;
        m_pixel_x_reg   <= m_pixel_x_next;
        m_pixel_y_reg   <= m_pixel_y_next;
        m_bounced_x_reg <= m_bounced_x_next;
        m_bounced_y_reg <= m_bounced_y_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_pixel_x   = m_pixel_x_reg;
    assign m_pixel_y   = m_pixel_y_reg;
    assign m_bounced_x = m_bounced_x_reg;
    assign m_bounced_y = m_bounced_y_reg;

    // load word lands in the particle state on the accept edge
    a_load_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode) |=>
            (pos_x_reg == $past(s_load_pos_x) && vel_y_reg == $past(s_load_vel_y)))
        else $error("load word not captured");

    // particle state only moves under the sequencer
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && !(s_valid && s_ready)) |=>
            ($stable(pos_x_reg) && $stable(pos_y_reg)
             && $stable(vel_x_reg) && $stable(vel_y_reg)))
        else $error("particle state changed while idle");

    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output step");

    // a load goes straight from idle to output and never bounces
    a_load_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && $past(state_reg == ST_IDLE)) |-> (!bx_reg && !by_reg))
        else $error("bounce flag set on load");

endmodule

`default_nettype wire
